FILE: rtl/core/cnc_pkg.sv
package cnc_pkg;

  localparam int DATA_W        = 64;
  localparam int DIV_STEPS     = DATA_W;
  localparam int FRAC_BITS_DEF = 32;

  localparam int REG_IDX_W = 2;
  localparam int ADDR_W    = 5;

  localparam logic [REG_IDX_W-1:0] REG_RATIO     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_CNT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BASE_TIME = 2'd2;

  localparam logic REQ_ABS   = 1'b0;
  localparam logic REQ_DELTA = 1'b1;

  // per-request control that rides along the divider chain
  typedef struct packed {
    logic is_delta;
    logic below;
    logic ovf;
    logic zero;
  } cnc_ctl_t;

endpackage

FILE: rtl/core/cnc_front.sv
module cnc_front
  import cnc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic              req_type,
  input  logic [DATA_W-1:0] count_value,
  input  logic [DATA_W-1:0] ratio,
  input  logic [DATA_W-1:0] base_count,
  output logic              out_valid,
  output cnc_ctl_t          out_ctl,
  output logic [DATA_W-1:0] out_rem,
  output logic [DATA_W-1:0] out_lq
);

  logic              v1;
  logic              delta1;
  logic              below1;
  logic [DATA_W-1:0] ticks1;

  logic [DATA_W:0]   fwd_diff;
  logic [DATA_W-1:0] back_diff;
  logic              is_below;
  logic [DATA_W-1:0] hi;

  assign fwd_diff  = {1'b0, count_value} - {1'b0, base_count};
  assign back_diff = base_count - count_value;
  assign is_below  = (req_type == REQ_ABS) && fwd_diff[DATA_W];

  // integer part of the dividend's upper word: ticks >> (64 - FRAC_BITS)
  assign hi = {{(DATA_W-FRAC_BITS){1'b0}}, ticks1[DATA_W-1 -: FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      delta1 <= (req_type == REQ_DELTA);
      below1 <= is_below;
      if (req_type == REQ_DELTA) begin
        ticks1 <= count_value;
      end else if (is_below) begin
        ticks1 <= back_diff;
      end else begin
        ticks1 <= fwd_diff[DATA_W-1:0];
      end

      out_ctl.is_delta <= delta1;
      out_ctl.below    <= below1;
      out_ctl.zero     <= (ratio == '0);
      out_ctl.ovf      <= (ratio != '0) && (hi >= ratio);
      out_rem          <= hi;
      out_lq           <= ticks1 << FRAC_BITS;
    end
  end

endmodule

FILE: rtl/core/cnc_div_cell.sv
module cnc_div_cell
  import cnc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [DATA_W-1:0] divisor,
  input  logic              in_valid,
  input  cnc_ctl_t          in_ctl,
  input  logic [DATA_W-1:0] in_rem,
  input  logic [DATA_W-1:0] in_lq,
  output logic              out_valid,
  output cnc_ctl_t          out_ctl,
  output logic [DATA_W-1:0] out_rem,
  output logic [DATA_W-1:0] out_lq
);

  logic              top;
  logic [DATA_W-1:0] rem_sh;
  logic [DATA_W:0]   trial;
  logic              take;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign top    = in_rem[DATA_W-1];
  assign rem_sh = {in_rem[DATA_W-2:0], in_lq[DATA_W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, divisor};
  assign take   = top || !trial[DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctl <= in_ctl;
      out_rem <= take ? trial[DATA_W-1:0] : rem_sh;
      out_lq  <= {in_lq[DATA_W-2:0], take};
    end
  end

endmodule

FILE: rtl/core/cnc_back.sv
module cnc_back
  import cnc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [DATA_W-1:0] base_time,
  input  logic              in_valid,
  input  cnc_ctl_t          in_ctl,
  input  logic [DATA_W-1:0] in_quot,
  output logic              out_valid,
  output logic [DATA_W-1:0] time_ns,
  output logic              before_base,
  output logic              saturated
);

  logic [DATA_W-1:0] dn;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   dif;
  logic [DATA_W-1:0] time_ns_next;
  logic              before_base_next;
  logic              saturated_next;

  always_comb begin
    if (in_ctl.zero) begin
      dn = '0;
    end else if (in_ctl.ovf) begin
      dn = '1;
    end else begin
      dn = in_quot;
    end
  end

  assign sum = {1'b0, base_time} + {1'b0, dn};
  assign dif = {1'b0, base_time} - {1'b0, dn};

  always_comb begin
    saturated_next   = in_ctl.ovf && !in_ctl.zero;
    before_base_next = 1'b0;
    if (in_ctl.is_delta) begin
      time_ns_next = dn;
    end else if (!in_ctl.below) begin
      if ((in_ctl.ovf && !in_ctl.zero) || sum[DATA_W]) begin
        time_ns_next   = '1;
        saturated_next = 1'b1;
      end else begin
        time_ns_next = sum[DATA_W-1:0];
      end
    end else if (!dif[DATA_W] && (dif[DATA_W-1:0] != '0)) begin
      time_ns_next = dif[DATA_W-1:0];
    end else begin
      // clamp at zero when the distance reaches or passes the base time
      time_ns_next     = '0;
      before_base_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      time_ns     <= time_ns_next;
      before_base <= before_base_next;
      saturated   <= saturated_next;
    end
  end

endmodule

FILE: rtl/core/counter_to_ns_convert_top.sv
// Channel   Dir  Request                          Fields (low bit first)
// s_*       in   conversion request               tdata: count_value; tuser: req_type
// m_*       out  converted time                   tdata: time_ns; tuser: before_base, saturated
// apb       in   config (ratio, base count/time)  8-byte registers at 0x00, 0x08, 0x10
//
// One request per cycle sustained while m_* is not stalled; each result passes, after its request
// is taken, through two front stages, 64 divider cells (one quotient bit each), one output stage.
// Reset clears all valid bits and the three config registers to zero.
// A result held at m_* stalls the whole chain; s_tready drops only then.
module counter_to_ns_convert_top
  import cnc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,   // [63:0] count_value
  input  logic              s_tuser,   // [0] req_type
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // [63:0] time_ns
  output logic [1:0]        m_tuser,   // [0] before_base, [1] saturated
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [DATA_W-1:0] ratio;
  logic [DATA_W-1:0] base_count;
  logic [DATA_W-1:0] base_time;
  logic              adv;
  logic [REG_IDX_W-1:0] reg_idx;

  logic              vld_ch [0:DIV_STEPS];
  cnc_ctl_t          ctl_ch [0:DIV_STEPS];
  logic [DATA_W-1:0] rem_ch [0:DIV_STEPS];
  logic [DATA_W-1:0] lq_ch  [0:DIV_STEPS];

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio      <= '0;
      base_count <= '0;
      base_time  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_RATIO:     ratio      <= pwdata;
        REG_BASE_CNT:  base_count <= pwdata;
        REG_BASE_TIME: base_time  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RATIO:     prdata = ratio;
      REG_BASE_CNT:  prdata = base_count;
      REG_BASE_TIME: prdata = base_time;
      default:       prdata = '0;
    endcase
  end

  // advance the chain unless the output register holds an untaken result
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  cnc_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (s_tvalid),
    .req_type   (s_tuser),
    .count_value(s_tdata),
    .ratio      (ratio),
    .base_count (base_count),
    .out_valid  (vld_ch[0]),
    .out_ctl    (ctl_ch[0]),
    .out_rem    (rem_ch[0]),
    .out_lq     (lq_ch[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    cnc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .divisor  (ratio),
      .in_valid (vld_ch[i]),
      .in_ctl   (ctl_ch[i]),
      .in_rem   (rem_ch[i]),
      .in_lq    (lq_ch[i]),
      .out_valid(vld_ch[i+1]),
      .out_ctl  (ctl_ch[i+1]),
      .out_rem  (rem_ch[i+1]),
      .out_lq   (lq_ch[i+1])
    );
  end

  cnc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .base_time  (base_time),
    .in_valid   (vld_ch[DIV_STEPS]),
    .in_ctl     (ctl_ch[DIV_STEPS]),
    .in_quot    (lq_ch[DIV_STEPS]),
    .out_valid  (m_tvalid),
    .time_ns    (m_tdata),
    .before_base(m_tuser[0]),
    .saturated  (m_tuser[1])
  );

endmodule
